// ===== src/tatm_pkg.sv =====
// Shared types and constants of the tilt average motor trim block.
package tatm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MOTOR_W  = 12;
  localparam int SCALE_W  = 16;
  localparam int PROD_W   = MOTOR_W + SCALE_W;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MOTORS   = 4;

  // Motor slots in the stage payload.
  localparam int M_FL = 0;
  localparam int M_FR = 1;
  localparam int M_BL = 2;
  localparam int M_BR = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GATE_LEVEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_SCALE     = 2'd2;

  // Register values after reset.
  localparam logic [MOTOR_W-1:0] GATE_LEVEL_RST     = 12'd300;
  localparam int                 TILT_THRESHOLD_RST = 256;
  localparam logic [SCALE_W-1:0] TRIM_SCALE_RST     = 16'd328;

  // Action codes.
  localparam logic [2:0] ACT_GATED      = 3'd0;
  localparam logic [2:0] ACT_LEVEL      = 3'd1;
  localparam logic [2:0] ACT_PITCH_HIGH = 3'd2;
  localparam logic [2:0] ACT_PITCH_LOW  = 3'd3;
  localparam logic [2:0] ACT_ROLL_HIGH  = 3'd4;
  localparam logic [2:0] ACT_ROLL_LOW   = 3'd5;

  // Configuration values that do not depend on the window length.
  typedef struct packed {
    logic [MOTOR_W-1:0] gate_level;
    logic [SCALE_W-1:0] trim_scale;
  } cfg_t;

  // Payload handed from the tilt stage to the trim stage.
  typedef struct packed {
    logic [2:0]                       action;
    logic [MOTORS-1:0][MOTOR_W-1:0]   motor;
    logic [MOTORS-1:0][PROD_W-1:0]    prod;
  } stage_t;

endpackage

// ===== src/tatm_cfg.sv =====
// Configuration registers of the tilt average motor trim block.
module tatm_cfg #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tatm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tatm_pkg::CFG_W-1:0]         cfg_data,
  output tatm_pkg::cfg_t                     cfg,
  output logic signed [$clog2(WINDOW_LEN)+tatm_pkg::SAMPLE_W-1:0] tilt_limit
);
  import tatm_pkg::*;

  localparam int SUM_W = $clog2(WINDOW_LEN) + SAMPLE_W;

  // The threshold is kept already multiplied by the window length, so the
  // mean test becomes a plain compare against the running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_level <= GATE_LEVEL_RST;
      cfg.trim_scale <= TRIM_SCALE_RST;
      tilt_limit     <= SUM_W'(TILT_THRESHOLD_RST * WINDOW_LEN);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GATE_LEVEL:     cfg.gate_level <= cfg_data[MOTOR_W-1:0];
        REG_TILT_THRESHOLD: tilt_limit <= SUM_W'(cfg_data[14:0]) * SUM_W'(WINDOW_LEN);
        REG_TRIM_SCALE:     cfg.trim_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/tatm_tilt.sv =====
// Tilt windows, running sums, action decision and trim products.
module tatm_tilt #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     take,
  input  logic signed [tatm_pkg::SAMPLE_W-1:0]     pitch_sample,
  input  logic signed [tatm_pkg::SAMPLE_W-1:0]     roll_sample,
  input  logic [tatm_pkg::MOTORS-1:0][tatm_pkg::MOTOR_W-1:0] motor,
  input  tatm_pkg::cfg_t                           cfg,
  input  logic signed [$clog2(WINDOW_LEN)+tatm_pkg::SAMPLE_W-1:0] tilt_limit,
  output tatm_pkg::stage_t                         stage
);
  import tatm_pkg::*;

  localparam int SUM_W = $clog2(WINDOW_LEN) + SAMPLE_W;

  logic signed [SAMPLE_W-1:0] pitch_taps [WINDOW_LEN];
  logic signed [SAMPLE_W-1:0] roll_taps  [WINDOW_LEN];
  logic signed [SUM_W-1:0]    pitch_sum;
  logic signed [SUM_W-1:0]    roll_sum;
  logic signed [SUM_W-1:0]    pitch_sum_next;
  logic signed [SUM_W-1:0]    roll_sum_next;
  logic signed [SUM_W-1:0]    neg_limit;
  logic                       gated;
  logic [2:0]                 action_next;

  // Any motor at or below the gate level holds the whole step off.
  always_comb begin
    gated = 1'b0;
    for (int i = 0; i < MOTORS; i++) begin
      if (motor[i] <= cfg.gate_level) gated = 1'b1;
    end
  end

  // The last tap holds the oldest sample, which leaves the window now.
  assign pitch_sum_next = pitch_sum + SUM_W'(pitch_sample)
                        - SUM_W'(pitch_taps[WINDOW_LEN-1]);
  assign roll_sum_next  = roll_sum + SUM_W'(roll_sample)
                        - SUM_W'(roll_taps[WINDOW_LEN-1]);
  assign neg_limit      = -tilt_limit;

  // Fixed priority: gated, pitch high, pitch low, roll high, roll low.
  always_comb begin
    if (gated) begin
      action_next = ACT_GATED;
    end else if (pitch_sum_next > tilt_limit) begin
      action_next = ACT_PITCH_HIGH;
    end else if (pitch_sum_next < neg_limit) begin
      action_next = ACT_PITCH_LOW;
    end else if (roll_sum_next > tilt_limit) begin
      action_next = ACT_ROLL_HIGH;
    end else if (roll_sum_next < neg_limit) begin
      action_next = ACT_ROLL_LOW;
    end else begin
      action_next = ACT_LEVEL;
    end
  end

  // Window shift lines and sums move only on a request that is not gated.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        pitch_taps[i] <= '0;
        roll_taps[i]  <= '0;
      end
      pitch_sum <= '0;
      roll_sum  <= '0;
    end else if (take && !gated) begin
      for (int i = WINDOW_LEN - 1; i > 0; i--) begin
        pitch_taps[i] <= pitch_taps[i-1];
        roll_taps[i]  <= roll_taps[i-1];
      end
      pitch_taps[0] <= pitch_sample;
      roll_taps[0]  <= roll_sample;
      pitch_sum     <= pitch_sum_next;
      roll_sum      <= roll_sum_next;
    end
  end

  // Stage payload: the decision, the drives and their scaled products.
  always_ff @(posedge clk) begin
    if (take) begin
      stage.action <= action_next;
      stage.motor  <= motor;
      for (int i = 0; i < MOTORS; i++) begin
        stage.prod[i] <= PROD_W'(motor[i]) * PROD_W'(cfg.trim_scale);
      end
    end
  end

endmodule

// ===== src/tatm_trim.sv =====
// Motor reduction and result register of the tilt average motor trim block.
module tatm_trim (
  input  logic                          clk,
  input  logic                          load,
  input  tatm_pkg::stage_t              stage,
  output logic [2:0]                    action,
  output logic [tatm_pkg::MOTOR_W-1:0]  out_front_left,
  output logic [tatm_pkg::MOTOR_W-1:0]  out_front_right,
  output logic [tatm_pkg::MOTOR_W-1:0]  out_back_left,
  output logic [tatm_pkg::MOTOR_W-1:0]  out_back_right
);
  import tatm_pkg::*;

  logic [MOTORS-1:0]              lower;
  logic [MOTORS-1:0][MOTOR_W-1:0] trimmed;
  logic [MOTORS-1:0][MOTOR_W-1:0] drive;
  logic [PROD_W:0]                rounded [MOTORS];
  logic [MOTOR_W:0]               cut [MOTORS];

  // Which pair of motors the action lowers.
  always_comb begin
    lower = '0;
    case (stage.action)
      ACT_PITCH_HIGH: begin
        lower[M_BL] = 1'b1;
        lower[M_BR] = 1'b1;
      end
      ACT_PITCH_LOW: begin
        lower[M_FL] = 1'b1;
        lower[M_FR] = 1'b1;
      end
      ACT_ROLL_HIGH: begin
        lower[M_FR] = 1'b1;
        lower[M_BR] = 1'b1;
      end
      ACT_ROLL_LOW: begin
        lower[M_FL] = 1'b1;
        lower[M_BL] = 1'b1;
      end
      default: lower = '0;
    endcase
  end

  // A lowered drive loses the product rounded up, never going below zero.
  always_comb begin
    for (int i = 0; i < MOTORS; i++) begin
      rounded[i] = {1'b0, stage.prod[i]} + (PROD_W+1)'(16'hFFFF);
      cut[i]     = rounded[i][PROD_W:SCALE_W];
      if (cut[i] >= {1'b0, stage.motor[i]}) begin
        trimmed[i] = '0;
      end else begin
        trimmed[i] = stage.motor[i] - cut[i][MOTOR_W-1:0];
      end
      drive[i] = lower[i] ? trimmed[i] : stage.motor[i];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      action          <= stage.action;
      out_front_left  <= drive[M_FL];
      out_front_right <= drive[M_FR];
      out_back_left   <= drive[M_BL];
      out_back_right  <= drive[M_BR];
    end
  end

endmodule

// ===== src/tilt_average_motor_trim_top.sv =====
// Top level of the tilt average motor trim block.
//
// Input channel: in_valid / in_stall carry one request of a pitch and a roll
// sample (Q8.8) and four motor drives. Output channel: out_valid / out_stall
// carry the action code and the four drives, one result per request, in order.
// A request moves at a clock edge where valid is high and stall is low.
// The block is a two-stage pipeline: the tilt stage updates the windows and
// sums, picks the action and forms the drive products; the trim stage
// subtracts the rounded products and fills the result register. One request is
// taken every cycle while the receiver keeps taking results.
// When the receiver stalls, the result register holds; the tilt stage takes
// one more request if it is empty, then in_stall rises until the result moves on.
// Reset (rst, synchronous) clears both windows and sums, empties the pipeline
// and loads the register defaults. Registers are written through cfg_write,
// cfg_index and cfg_data, one per cycle. The user must write them only while
// no request is in flight; the block itself does not enforce this.
module tilt_average_motor_trim_top #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [tatm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tatm_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tatm_pkg::SAMPLE_W-1:0] pitch_sample,
  input  logic signed [tatm_pkg::SAMPLE_W-1:0] roll_sample,
  input  logic [tatm_pkg::MOTOR_W-1:0]         motor_front_left,
  input  logic [tatm_pkg::MOTOR_W-1:0]         motor_front_right,
  input  logic [tatm_pkg::MOTOR_W-1:0]         motor_back_left,
  input  logic [tatm_pkg::MOTOR_W-1:0]         motor_back_right,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           action,
  output logic [tatm_pkg::MOTOR_W-1:0]         out_front_left,
  output logic [tatm_pkg::MOTOR_W-1:0]         out_front_right,
  output logic [tatm_pkg::MOTOR_W-1:0]         out_back_left,
  output logic [tatm_pkg::MOTOR_W-1:0]         out_back_right
);
  import tatm_pkg::*;

  localparam int SUM_W = $clog2(WINDOW_LEN) + SAMPLE_W;

  cfg_t                       cfg;
  logic signed [SUM_W-1:0]    tilt_limit;
  stage_t                     stage;
  logic [MOTORS-1:0][MOTOR_W-1:0] motor;
  logic                       stage_valid;
  logic                       take;
  logic                       move_out;

  // Pipeline flow: the result register frees when it is empty or taken.
  assign move_out = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !move_out;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        stage_valid <= 1'b1;
      end else if (move_out) begin
        stage_valid <= 1'b0;
      end
      if (move_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Gather the motor drives in slot order.
  always_comb begin
    motor[M_FL] = motor_front_left;
    motor[M_FR] = motor_front_right;
    motor[M_BL] = motor_back_left;
    motor[M_BR] = motor_back_right;
  end

  tatm_cfg #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .tilt_limit (tilt_limit)
  );

  tatm_tilt #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_tilt (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .pitch_sample (pitch_sample),
    .roll_sample  (roll_sample),
    .motor        (motor),
    .cfg          (cfg),
    .tilt_limit   (tilt_limit),
    .stage        (stage)
  );

  tatm_trim u_trim (
    .clk             (clk),
    .load            (move_out),
    .stage           (stage),
    .action          (action),
    .out_front_left  (out_front_left),
    .out_front_right (out_front_right),
    .out_back_left   (out_back_left),
    .out_back_right  (out_back_right)
  );

endmodule
